FILE: design/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the PID speed controller
// Field widths, datapath widths, control word encoding and the microprogram.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int SumW    = 32;
  localparam int SpeedW  = 16;
  localparam int ErrW    = SpeedW + 1;
  localparam int FracSh  = 16;
  localparam int BigW    = ErrW + FracSh;
  localparam int SmW     = BigW;
  localparam int DiffW   = BigW + 1;
  localparam int DW      = ErrW + 1 + FracSh;
  localparam int GainW   = 24;
  localparam int AlphaW  = 16;
  localparam int LimW    = 10;
  localparam int DutyW   = LimW + 1;
  localparam int MulAW   = (SumW > DiffW) ? SumW : DiffW;
  localparam int MulBW   = GainW + 1;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = SumW + 44;
  localparam int OutSh   = 36;
  localparam int QW      = AccW - OutSh;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int StepW   = 4;

  typedef struct packed {
    logic signed [SpeedW-1:0] target_speed;
    logic signed [SpeedW-1:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [DutyW-1:0] duty;
    logic                    clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic                    deriv_mode;
    logic [AlphaW-1:0]       filter_alpha;
    logic [LimW-1:0]         output_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:    24'sd30802,
    integ_gain:   24'sd17236,
    deriv_gain:   -24'sd5243,
    deriv_mode:   1'b0,
    filter_alpha: 16'd32768,
    output_limit: 10'd100
  };

  typedef enum logic [1:0] {A_ERR, A_SUM, A_DIFF, A_D} mul_a_sel_t;
  typedef enum logic [1:0] {B_PG, B_IG, B_DG, B_ALPHA} mul_b_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_ADD16, ACC_ADD} acc_op_t;
  typedef enum logic [2:0] {OP_NOP, OP_SUM, OP_FILT, OP_DFILT, OP_DRAW, OP_DONE} dp_op_t;
  typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_RAW} jmp_t;

  typedef struct packed {
    mul_a_sel_t       mul_a;
    mul_b_sel_t       mul_b;
    logic             mul_en;
    acc_op_t          acc;
    dp_op_t           op;
    jmp_t             jmp;
    logic [StepW-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic      load;
    logic      fire;
    ctl_word_t word;
  } dp_ctl_t;

  localparam logic [StepW-1:0] StepSum   = 4'd0;
  localparam logic [StepW-1:0] StepAccP  = 4'd1;
  localparam logic [StepW-1:0] StepFilt  = 4'd2;
  localparam logic [StepW-1:0] StepAccI  = 4'd3;
  localparam logic [StepW-1:0] StepDFilt = 4'd4;
  localparam logic [StepW-1:0] StepDRaw  = 4'd5;
  localparam logic [StepW-1:0] StepMulD  = 4'd6;
  localparam logic [StepW-1:0] StepAccD  = 4'd7;
  localparam logic [StepW-1:0] StepDone  = 4'd8;

  function automatic ctl_word_t ucode(input logic [StepW-1:0] step);
    ctl_word_t w;
    w = '{mul_a: A_ERR, mul_b: B_PG, mul_en: 1'b0, acc: ACC_HOLD,
          op: OP_NOP, jmp: JMP_NONE, target: StepSum};
    unique case (step)
      StepSum: begin
        w.op = OP_SUM;  w.mul_a = A_ERR;  w.mul_b = B_PG;    w.mul_en = 1'b1;
      end
      StepAccP: begin
        w.acc = ACC_ADD16; w.mul_a = A_DIFF; w.mul_b = B_ALPHA; w.mul_en = 1'b1;
      end
      StepFilt: begin
        w.op = OP_FILT; w.mul_a = A_SUM;  w.mul_b = B_IG;    w.mul_en = 1'b1;
      end
      StepAccI: begin
        w.acc = ACC_ADD16; w.jmp = JMP_RAW; w.target = StepDRaw;
      end
      StepDFilt: begin
        w.op = OP_DFILT; w.jmp = JMP_ALWAYS; w.target = StepMulD;
      end
      StepDRaw: begin
        w.op = OP_DRAW;
      end
      StepMulD: begin
        w.mul_a = A_D; w.mul_b = B_DG; w.mul_en = 1'b1;
      end
      StepAccD: begin
        w.acc = ACC_ADD;
      end
      StepDone: begin
        w.op = OP_DONE;
      end
      default: begin
        w.op = OP_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/psc_cfg.sv
// ----------------------------------------------------------------------------
// psc_cfg: configuration register file
// APB-style write and read access to gains, derivative mode, filter and limit.
// ----------------------------------------------------------------------------
module psc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [psc_pkg::AddrW-1:0] paddr,
  input  logic [psc_pkg::DataW-1:0] pwdata,
  output logic [psc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output psc_pkg::cfg_t             cfg
);
  import psc_pkg::*;

  localparam logic [2:0] RegProp  = 3'd0;
  localparam logic [2:0] RegInteg = 3'd1;
  localparam logic [2:0] RegDeriv = 3'd2;
  localparam logic [2:0] RegMode  = 3'd3;
  localparam logic [2:0] RegAlpha = 3'd4;
  localparam logic [2:0] RegLimit = 3'd5;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[AddrW-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        RegProp:  cfg_nxt.prop_gain    = pwdata[GainW-1:0];
        RegInteg: cfg_nxt.integ_gain   = pwdata[GainW-1:0];
        RegDeriv: cfg_nxt.deriv_gain   = pwdata[GainW-1:0];
        RegMode:  cfg_nxt.deriv_mode   = pwdata[0];
        RegAlpha: cfg_nxt.filter_alpha = pwdata[AlphaW-1:0];
        RegLimit: cfg_nxt.output_limit = pwdata[LimW-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegProp:  prdata = DataW'(cfg_r.prop_gain);
      RegInteg: prdata = DataW'(cfg_r.integ_gain);
      RegDeriv: prdata = DataW'(cfg_r.deriv_gain);
      RegMode:  prdata = DataW'(cfg_r.deriv_mode);
      RegAlpha: prdata = DataW'(cfg_r.filter_alpha);
      RegLimit: prdata = DataW'(cfg_r.output_limit);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/psc_seq.sv
// ----------------------------------------------------------------------------
// psc_seq: microprogram sequencer
// Step counter over the control ROM with conditional and unconditional jumps, input handshake and output hold.
// ----------------------------------------------------------------------------
module psc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             deriv_mode,
  input  logic             out_hold,
  output psc_pkg::dp_ctl_t ctl
);
  import psc_pkg::*;

  logic             busy_r;
  logic [StepW-1:0] step_r;
  ctl_word_t        word;
  logic             accept;
  logic             fire;
  logic             take_jump;

  assign word     = ucode(step_r);
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign fire     = busy_r && !((word.op == OP_DONE) && out_hold);

  always_comb begin
    unique case (word.jmp)
      JMP_NONE:   take_jump = 1'b0;
      JMP_ALWAYS: take_jump = 1'b1;
      JMP_RAW:    take_jump = !deriv_mode;
      default:    take_jump = 1'b0;
    endcase
  end

  assign ctl.load = accept;
  assign ctl.fire = fire;
  assign ctl.word = word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= StepSum;
    end else if (accept) begin
      busy_r <= 1'b1;
      step_r <= StepSum;
    end else if (fire) begin
      if (word.op == OP_DONE) begin
        busy_r <= 1'b0;
      end else if (take_jump) begin
        step_r <= word.target;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= StepDone))
    else $error("step counter beyond program end");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (word.op == OP_DONE)) |=> !busy_r)
    else $error("sequencer still busy after final step");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && (step_r == StepSum)))
    else $error("accepted beat did not start program");

endmodule

FILE: design/psc_dp.sv
// ----------------------------------------------------------------------------
// psc_dp: PID datapath
// Shared multiplier, accumulator, loop state and output register.
// ----------------------------------------------------------------------------
module psc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::dp_ctl_t   ctl,
  input  psc_pkg::cfg_t      cfg,
  input  psc_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output psc_pkg::out_item_t out_data,
  output logic               out_hold
);
  import psc_pkg::*;

  logic signed [ErrW-1:0]   e_r;
  logic signed [SumW-1:0]   error_sum_r;
  logic signed [ErrW-1:0]   last_r;
  logic signed [SmW-1:0]    s_r;
  logic signed [DiffW-1:0]  diff_r;
  logic signed [DW-1:0]     d_r;
  logic signed [ProdW-1:0]  p_r;
  logic signed [AccW-1:0]   acc_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic signed [BigW-1:0]         big;
  logic signed [MulAW-1:0]        mul_a;
  logic signed [MulBW-1:0]        mul_b;
  logic signed [ProdW-1:0]        prod;
  logic signed [AccW-1:0]         p_ext;
  logic signed [AccW-1:0]         acc_nxt;
  logic signed [SumW:0]           sum_wide;
  logic signed [SumW-1:0]         sum_sat;
  logic signed [ProdW-FracSh-1:0] fstep;
  logic signed [ProdW-FracSh-1:0] s_wide;
  logic signed [SmW-1:0]          s_nxt;
  logic signed [DiffW-1:0]        diff_nxt;
  logic signed [DW-1:0]           d_filt;
  logic signed [ErrW:0]           e_delta;
  logic signed [DW-1:0]           d_raw;
  logic signed [QW-1:0]           q;
  logic signed [QW-1:0]           res;
  logic signed [QW-1:0]           lim_q;
  logic signed [QW-1:0]           lim_neg;
  logic                           rem_nz;
  logic                           done_fire;
  out_item_t                      out_nxt;
  logic signed [DutyW-1:0]        lim_duty;

  assign big = {e_r, {FracSh{1'b0}}};

  always_comb begin
    case (ctl.word.mul_a)
      A_ERR:   mul_a = MulAW'(e_r);
      A_SUM:   mul_a = MulAW'(error_sum_r);
      A_DIFF:  mul_a = MulAW'(diff_r);
      A_D:     mul_a = MulAW'(d_r);
      default: mul_a = '0;
    endcase
    case (ctl.word.mul_b)
      B_PG:    mul_b = MulBW'(cfg.prop_gain);
      B_IG:    mul_b = MulBW'(cfg.integ_gain);
      B_DG:    mul_b = MulBW'(cfg.deriv_gain);
      B_ALPHA: mul_b = MulBW'({1'b0, cfg.filter_alpha});
      default: mul_b = '0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_ext = AccW'(p_r);

  always_comb begin
    case (ctl.word.acc)
      ACC_ADD16: acc_nxt = acc_r + (p_ext <<< FracSh);
      ACC_ADD:   acc_nxt = acc_r + p_ext;
      default:   acc_nxt = acc_r;
    endcase
  end

  assign sum_wide = (SumW+1)'(error_sum_r) + (SumW+1)'(e_r);
  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  assign fstep    = p_r[ProdW-1:FracSh];
  assign s_wide   = (ProdW-FracSh)'(s_r) + fstep;
  assign s_nxt    = s_wide[SmW-1:0];
  assign diff_nxt = DiffW'(big) - DiffW'(s_r);
  assign d_filt   = DW'(big) - DW'(s_r);
  assign e_delta  = (ErrW+1)'(e_r) - (ErrW+1)'(last_r);
  assign d_raw    = {e_delta, {FracSh{1'b0}}};

  assign q       = acc_r[AccW-1:OutSh];
  assign rem_nz  = |acc_r[OutSh-1:0];
  assign res     = q + QW'(acc_r[AccW-1] && rem_nz);
  assign lim_q   = QW'({1'b0, cfg.output_limit});
  assign lim_neg = -lim_q;

  always_comb begin
    if (res > lim_q) begin
      out_nxt.duty    = lim_q[DutyW-1:0];
      out_nxt.clamped = 1'b1;
    end else if (res < lim_neg) begin
      out_nxt.duty    = lim_neg[DutyW-1:0];
      out_nxt.clamped = 1'b1;
    end else begin
      out_nxt.duty    = res[DutyW-1:0];
      out_nxt.clamped = 1'b0;
    end
  end

  assign done_fire = ctl.fire && (ctl.word.op == OP_DONE);
  assign out_hold  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign lim_duty  = {1'b0, cfg.output_limit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      last_r      <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.fire) begin
        case (ctl.word.op) inside
          OP_SUM:            error_sum_r <= sum_sat;
          OP_FILT:           s_r         <= s_nxt;
          OP_DFILT, OP_DRAW: last_r      <= e_r;
          default: ;
        endcase
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      e_r   <= ErrW'(in_data.target_speed) - ErrW'(in_data.measured_speed);
      acc_r <= '0;
    end else if (ctl.fire) begin
      acc_r <= acc_nxt;
      if (ctl.word.mul_en) begin
        p_r <= prod;
      end
      case (ctl.word.op)
        OP_SUM:   diff_r <= diff_nxt;
        OP_DFILT: d_r    <= d_filt;
        OP_DRAW:  d_r    <= d_raw;
        default: ;
      endcase
    end
    if (done_fire) begin
      out_r <= out_nxt;
    end
  end

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.duty <= lim_duty) && (out_r.duty >= -lim_duty)))
    else $error("duty beyond output limit");

  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clamped) |-> ((out_r.duty == lim_duty) || (out_r.duty == -lim_duty)))
    else $error("clamped beat not at the limit");

endmodule

FILE: design/pid_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_speed_controller: fixed-point PID speed loop with output clamp
// Each beat runs the 8-step microprogram, which shares one multiplier
// and one accumulator; no new beat is taken until its final step is done,
// and that step waits while the previous result is stalled at the output.
// Reset: synchronous active-low; clears integrator, last error and filter,
// loads default gains; no clearing pass, input is taken right after reset.
// ----------------------------------------------------------------------------
module pid_speed_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  psc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output psc_pkg::out_item_t        out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [psc_pkg::AddrW-1:0] paddr,
  input  logic [psc_pkg::DataW-1:0] pwdata,
  output logic [psc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import psc_pkg::*;

  cfg_t    cfg;
  dp_ctl_t ctl;
  logic    out_hold;

  psc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .deriv_mode (cfg.deriv_mode),
    .out_hold   (out_hold),
    .ctl        (ctl)
  );

  psc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_hold  (out_hold)
  );

endmodule

FILE: tb/sv/tb_pid_speed_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_speed_controller: self-checking bench for the PID speed loop
// Speed beats go in from a queue through a clocked driver. A bit-exact
// integer model of the loop predicts duty and clamp for every beat, and a
// clocked monitor checks the results in order. Gains, mode, filter and limit
// are changed over the bus between phases, including the extremes. A run at
// full error drives the integrator hard in both directions.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_speed_controller;
  import psc_pkg::*;

  localparam int RegProp   = 0;
  localparam int RegInteg  = 1;
  localparam int RegDeriv  = 2;
  localparam int RegMode   = 3;
  localparam int RegAlpha  = 4;
  localparam int RegLimit  = 5;
  localparam int RegSpare0 = 6;
  localparam int RegSpare1 = 7;

  localparam longint SumMax = (longint'(1) <<< (SumW - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  pid_speed_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // loop settings as the block should hold them
  longint gain_p = 30802;
  longint gain_i = 17236;
  longint gain_d = -5243;
  bit use_filter = 1'b0;
  longint filt_alpha = 32768;
  longint duty_limit = 100;

  // loop state
  longint err_sum = 0;
  longint last_err = 0;
  longint smooth_err = 0;

  in_item_t speed_q[$];
  out_item_t duty_exp_q[$];
  int bad_count = 0;
  int in_gap = 0;
  int out_hold = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit no_idle = 1'b0;
  bit feed_hold = 1'b0;

  function automatic out_item_t next_duty(in_item_t beat);
    logic signed [15:0] tgt, meas;
    longint err, sum, big, sm, dterm, pv, iv, dv;
    logic signed [95:0] wp, wi, wd, acc, mag, q, lim;
    out_item_t r;
    tgt = beat.target_speed;
    meas = beat.measured_speed;
    err = longint'(tgt) - longint'(meas);
    sum = err_sum + err;
    if (sum > SumMax) sum = SumMax;
    if (sum < SumMin) sum = SumMin;
    big = err * 65536;
    sm = smooth_err + ((filt_alpha * (big - smooth_err)) >>> 16);
    if (use_filter) dterm = big - sm;
    else dterm = (err - last_err) * 65536;
    pv = gain_p * err;
    iv = gain_i * sum;
    dv = gain_d * dterm;
    wp = pv;
    wi = iv;
    wd = dv;
    acc = ((wp + wi) <<< 16) + wd;
    if (acc < 0) begin
      mag = -acc;
      q = -(mag >>> 36);
    end else begin
      q = acc >>> 36;
    end
    lim = duty_limit;
    r.clamped = 1'b0;
    if (q > lim) begin
      q = lim;
      r.clamped = 1'b1;
    end else if (q < -lim) begin
      q = -lim;
      r.clamped = 1'b1;
    end
    r.duty = q[DutyW-1:0];
    err_sum = sum;
    last_err = err;
    smooth_err = sm;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        duty_exp_q.push_back(next_duty(in_data));
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        in_gap = (no_idle || in_quiet) ? 0 : $urandom_range(0, 10);
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (speed_q.size() > 0 && !feed_hold) begin
          in_valid <= 1'b1;
          in_data <= speed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_exp_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected beat duty %0d clamped %0b", $realtime,
                     $signed(out_data.duty), out_data.clamped);
        end else begin
          want = duty_exp_q.pop_front();
          if (out_data.duty !== want.duty || out_data.clamped !== want.clamped) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: duty exp %0d clamped exp %0b, got duty %0d clamped %0b",
                       $realtime, $signed(want.duty), want.clamped,
                       $signed(out_data.duty), out_data.clamped);
          end
        end
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_hold = (no_idle || out_quiet) ? 0 : $urandom_range(0, 10);
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    logic signed [23:0] g;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    g = val[23:0];
    case (idx)
      RegProp: gain_p = g;
      RegInteg: gain_i = g;
      RegDeriv: gain_d = g;
      RegMode: use_filter = val[0];
      RegAlpha: filt_alpha = val[AlphaW-1:0];
      RegLimit: duty_limit = val[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] mode, logic [31:0] alpha, logic [31:0] limit);
    write_reg(RegProp, kp);
    write_reg(RegInteg, ki);
    write_reg(RegDeriv, kd);
    write_reg(RegMode, mode);
    write_reg(RegAlpha, alpha);
    write_reg(RegLimit, limit);
  endtask

  task automatic drain();
    @(negedge clk);
    while (speed_q.size() != 0 || in_valid || duty_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_speed(logic [15:0] tgt, logic [15:0] meas);
    in_item_t b;
    b.target_speed = tgt;
    b.measured_speed = meas;
    speed_q.push_back(b);
  endtask

  task automatic push_random_speed();
    logic [15:0] tgt, meas;
    tgt = $urandom;
    if ($urandom_range(0, 2) == 0) meas = $urandom;
    else meas = tgt + 16'($urandom_range(0, 1023)) - 16'd512;
    push_speed(tgt, meas);
  endtask

  function automatic logic [31:0] rand_gain();
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    v = int'($urandom_range(0, 262143)) - 131072;
    return v;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_speed(16'd0, 16'd0);
    push_speed(16'h7fff, 16'h8000);
    push_speed(16'h7fff, 16'h8000);
    push_speed(16'h8000, 16'h7fff);
    push_speed(16'h8000, 16'h7fff);
    push_speed(16'h8000, 16'h8000);
    push_speed(16'h7fff, 16'h7fff);
    push_speed(16'd1, 16'd0);
    push_speed(16'd0, 16'd1);
    push_speed(16'hffff, 16'hffff);
    push_speed(16'd1600, 16'd0);
    push_speed(16'd0, 16'd1600);
    drain();

    write_all(32'h007fffff, 32'h00800000, 32'h007fffff, 32'd1, 32'd65535, 32'd1023);
    push_speed(16'h7fff, 16'h8000);
    push_speed(16'h8000, 16'h7fff);
    push_speed(16'd0, 16'd0);
    push_speed(16'd320, 16'd0);
    drain();

    write_reg(RegSpare0, 32'hffffffff);
    write_reg(RegSpare1, 32'h00000000);
    push_speed(16'd100, 16'd40);
    push_speed(16'h8000, 16'h8000);
    push_speed(16'd40, 16'd100);
    drain();

    // run the integrator at full error up, then down, back to back
    write_all(32'd0, 32'd1, 32'd0, 32'd0, 32'd32768, 32'd1023);
    no_idle = 1'b1;
    repeat (40) push_speed(16'h7fff, 16'h8000);
    repeat (40) push_speed(16'h8000, 16'h7fff);
    drain();
    no_idle = 1'b0;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_all(32'h00800000, 32'h007fffff, 32'h00800000, 32'd0, 32'd0, 32'd0);
        1: write_all(32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1000);
        2: write_all(32'd30802, 32'd17236, -32'sd5243, 32'd0, 32'd32768, 32'd100);
        default: write_all(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 1),
                           $urandom_range(0, 65535), $urandom_range(0, 1023));
      endcase
      repeat (140) push_random_speed();
      if (p == 3) begin
        @(negedge clk);
        while (speed_q.size() > 75) @(negedge clk);
        feed_hold = 1'b1;
        while (in_valid || duty_exp_q.size() != 0) @(negedge clk);
        feed_hold = 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (bad_count == 0) begin
      $display("pid_speed_controller test passed");
    end else begin
      $display("pid_speed_controller test failed");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("pid_speed_controller test failed");
    $finish;
  end

endmodule
